// ===== rtl/core/ihex_pkg.sv =====
// ihex_pkg: shared constants, types and the hex digit decoder for the hex record loader
// used by ihex_parser and intel_hex_record_loader; no other dependencies
`timescale 1ns / 1ps

package ihex_pkg;

    // characters at or past this column are dropped until the newline
    localparam int LINE_LIMIT = 256;
    localparam int COL_W      = $clog2(LINE_LIMIT + 1);
    localparam int CMP_W      = (COL_W > 8) ? COL_W : 8;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_EXT  = 8'h04;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic CFG_PAYLOAD_BASE = 1'b0;
    localparam logic CFG_REGION_END   = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [31:0] offset;
        logic [7:0]  data_byte;
    } t_result;

    // anything that is not a hex digit decodes as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            v = c - CH_LA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/core/ihex_parser.sv =====
// ihex_parser: line and record state of the hex record loader, one character per step
// depends on ihex_pkg
`timescale 1ns / 1ps

module ihex_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_char,
    input  logic [31:0]             i_payload_base,
    input  logic [32:0]             i_region_end,
    output ihex_pkg::t_result       o_res
);

    typedef enum logic [1:0] {
        M_START,
        M_REC,
        M_SKIP
    } t_mode;

    t_mode                      r_mode,   n_mode;
    logic [ihex_pkg::COL_W-1:0] r_column, n_column;
    logic [7:0]                 r_len,    n_len;
    logic [15:0]                r_addr,   n_addr;
    logic [7:0]                 r_kind,   n_kind;
    logic [15:0]                r_upper,  n_upper;
    logic [15:0]                r_ext,    n_ext;
    logic [3:0]                 r_high,   n_high;
    logic                       r_win,    n_win;
    logic                       r_finished, n_finished;

    logic [3:0]                 digit;
    logic [7:0]                 kind_new;
    logic [15:0]                ext_new;
    logic [31:0]                abs_addr;
    logic                       win_ok;
    logic [ihex_pkg::COL_W-1:0] data_col;
    logic [ihex_pkg::COL_W-1:0] idx;
    logic                       close_hit;
    logic [15:0]                close_upper;
    ihex_pkg::t_result          res;

    assign digit    = ihex_pkg::hex_digit(i_char);
    assign kind_new = {r_kind[3:0], digit};
    assign ext_new  = {r_ext[11:0], digit};
    assign abs_addr = {r_upper, r_addr};
    assign win_ok   = (abs_addr >= i_payload_base) &&
                      (({1'b0, abs_addr} + 33'(r_len)) <= i_region_end);
    assign data_col = r_column - ihex_pkg::COL_W'(9);
    assign idx      = data_col >> 1;

    // short extended address record: shift the collected digits up
    assign close_hit = (r_mode == M_REC) && (r_kind == ihex_pkg::REC_EXT) &&
                       (r_column >= ihex_pkg::COL_W'(9)) && (r_column <= ihex_pkg::COL_W'(12));
    always_comb begin
        case (r_column)
            ihex_pkg::COL_W'(10): close_upper = {r_ext[3:0], 12'h000};
            ihex_pkg::COL_W'(11): close_upper = {r_ext[7:0], 8'h00};
            ihex_pkg::COL_W'(12): close_upper = {r_ext[11:0], 4'h0};
            default:              close_upper = 16'h0000;
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_column   = r_column;
        n_len      = r_len;
        n_addr     = r_addr;
        n_kind     = r_kind;
        n_upper    = r_upper;
        n_ext      = r_ext;
        n_high     = r_high;
        n_win      = r_win;
        n_finished = r_finished;
        res        = '0;

        if (i_step && !r_finished) begin
            if (i_char == ihex_pkg::CH_LF) begin
                if (close_hit) begin
                    n_upper = close_upper;
                end
                n_mode   = M_START;
                n_column = '0;
            end else begin
                case (r_mode)
                    M_START: begin
                        if (i_char == ihex_pkg::CH_COLON) begin
                            n_mode   = M_REC;
                            n_column = ihex_pkg::COL_W'(1);
                            n_len    = '0;
                            n_addr   = '0;
                            n_kind   = '0;
                            n_ext    = '0;
                            n_high   = '0;
                            n_win    = 1'b0;
                        end else begin
                            n_mode = M_SKIP;
                        end
                    end
                    M_REC: begin
                        if (i_char == ihex_pkg::CH_CR) begin
                            if (close_hit) begin
                                n_upper = close_upper;
                            end
                            n_mode = M_SKIP;
                        end else if (r_column < ihex_pkg::COL_W'(ihex_pkg::LINE_LIMIT)) begin
                            n_column = r_column + 1'b1;
                            if (r_column <= ihex_pkg::COL_W'(2)) begin
                                n_len = {r_len[3:0], digit};
                            end else if (r_column <= ihex_pkg::COL_W'(6)) begin
                                n_addr = {r_addr[11:0], digit};
                            end else if (r_column <= ihex_pkg::COL_W'(8)) begin
                                n_kind = kind_new;
                                if (r_column == ihex_pkg::COL_W'(8)) begin
                                    n_win = (kind_new == ihex_pkg::REC_DATA) && win_ok;
                                    if (kind_new == ihex_pkg::REC_EOF) begin
                                        n_finished = 1'b1;
                                        res.valid  = 1'b1;
                                        res.kind   = ihex_pkg::KIND_END;
                                    end
                                end
                            end else if (r_kind == ihex_pkg::REC_EXT) begin
                                if (r_column <= ihex_pkg::COL_W'(12)) begin
                                    n_ext = ext_new;
                                    if (r_column == ihex_pkg::COL_W'(12)) begin
                                        n_upper = ext_new;
                                    end
                                end
                            end else if (r_kind == ihex_pkg::REC_DATA && r_win) begin
                                if (ihex_pkg::CMP_W'(idx) < ihex_pkg::CMP_W'(r_len)) begin
                                    if (!data_col[0]) begin
                                        n_high = digit;
                                    end else begin
                                        res.valid     = 1'b1;
                                        res.kind      = ihex_pkg::KIND_WRITE;
                                        res.offset    = abs_addr + 32'(idx) - i_payload_base;
                                        res.data_byte = {r_high, digit};
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_START;
            r_column   <= '0;
            r_len      <= '0;
            r_addr     <= '0;
            r_kind     <= '0;
            r_upper    <= '0;
            r_ext      <= '0;
            r_high     <= '0;
            r_win      <= 1'b0;
            r_finished <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_column   <= n_column;
            r_len      <= n_len;
            r_addr     <= n_addr;
            r_kind     <= n_kind;
            r_upper    <= n_upper;
            r_ext      <= n_ext;
            r_high     <= n_high;
            r_win      <= n_win;
            r_finished <= n_finished;
        end
    end

    // once the end record is seen nothing more comes out
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !o_res.valid)
        else $error("result after end record");

    // a result only ever comes from a character being consumed inside a record
    a_result_in_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (i_step && r_mode == M_REC))
        else $error("result outside a record");

    // a data write only comes from the second digit of a pair in a window record
    a_write_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == ihex_pkg::KIND_WRITE) |->
            (r_win && r_column >= ihex_pkg::COL_W'(10) && data_col[0]))
        else $error("data write outside window or off a pair");

endmodule

// ===== rtl/core/intel_hex_record_loader.sv =====
// intel_hex_record_loader: top level, input and result registers around the record parser
// depends on ihex_pkg and ihex_parser
`timescale 1ns / 1ps

// Takes hex record text one character per beat and yields byte writes (offset from payload
// base) for data records inside the window, and one end beat for the end of file record;
// after that every character is taken and dropped until reset. The block takes one
// character per cycle when the result side keeps up: a character is held in the input
// register, is decoded in a single pass, and its result, if any, lands in the result
// register. Only a stalled result register holds the input side back. Registers are to be
// written through the cfg port only between records; the block itself does not enforce it.
module intel_hex_record_loader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [32:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [31:0] o_offset,
    output logic [7:0]  o_data_byte
);

    logic [31:0]       r_payload_base;
    logic [32:0]       r_region_end;
    logic              r_in_valid;
    logic [7:0]        r_char;
    logic              r_out_valid;
    logic              r_kind;
    logic [31:0]       r_offset;
    logic [7:0]        r_data_byte;

    logic              advance;
    logic              step;
    ihex_pkg::t_result res;

    // the held character moves on whenever the result register is free or draining
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    ihex_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_char         (r_char),
        .i_payload_base (r_payload_base),
        .i_region_end   (r_region_end),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_base <= '0;
            r_region_end   <= 33'h1_0000_0000;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ihex_pkg::CFG_PAYLOAD_BASE: r_payload_base <= i_cfg_wdata[31:0];
                    ihex_pkg::CFG_REGION_END:   r_region_end   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= step && res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_char_in;
        end
        if (advance && step && res.valid) begin
            r_kind      <= res.kind;
            r_offset    <= res.offset;
            r_data_byte <= res.data_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_offset    = r_offset;
    assign o_data_byte = r_data_byte;

endmodule
